FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the tokenizer back end.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define STOK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition never holds outside reset.
`define STOK_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define STOK_ASSERT(label, clk, rst, prop)
`define STOK_NEVER(label, clk, rst, cond)

`endif

`endif

FILE: rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// Source tokenizer package
// Token kind codes, character classes and lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

   localparam int KIND_W      = 6;
   localparam int POS_W       = 32;
   localparam int TOKEN_LEN_W = 11;
   localparam int HEAD_LEN    = 8;
   localparam int KW_COUNT    = 13;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_ERROR  = 6'd0;
   localparam logic [KIND_W-1:0] KIND_IDENT  = 6'd1;
   localparam logic [KIND_W-1:0] KIND_INT    = 6'd2;
   localparam logic [KIND_W-1:0] KIND_FLOAT  = 6'd3;
   localparam logic [KIND_W-1:0] KIND_STRING = 6'd4;
   localparam logic [KIND_W-1:0] KIND_LPAREN = 6'd5;
   localparam logic [KIND_W-1:0] KIND_RPAREN = 6'd6;
   localparam logic [KIND_W-1:0] KIND_LBRACK = 6'd7;
   localparam logic [KIND_W-1:0] KIND_RBRACK = 6'd8;
   localparam logic [KIND_W-1:0] KIND_LBRACE = 6'd9;
   localparam logic [KIND_W-1:0] KIND_RBRACE = 6'd10;
   localparam logic [KIND_W-1:0] KIND_COMMA  = 6'd11;
   localparam logic [KIND_W-1:0] KIND_SEMI   = 6'd12;
   localparam logic [KIND_W-1:0] KIND_PLUS   = 6'd13;
   localparam logic [KIND_W-1:0] KIND_MINUS  = 6'd14;
   localparam logic [KIND_W-1:0] KIND_SLASH  = 6'd15;
   localparam logic [KIND_W-1:0] KIND_STAR   = 6'd16;
   localparam logic [KIND_W-1:0] KIND_ASSIGN = 6'd17;
   localparam logic [KIND_W-1:0] KIND_LT     = 6'd18;
   localparam logic [KIND_W-1:0] KIND_GT     = 6'd19;
   localparam logic [KIND_W-1:0] KIND_MOD    = 6'd20;
   localparam logic [KIND_W-1:0] KIND_NOT    = 6'd21;
   localparam logic [KIND_W-1:0] KIND_INC    = 6'd22;
   localparam logic [KIND_W-1:0] KIND_DEC    = 6'd23;
   localparam logic [KIND_W-1:0] KIND_POW    = 6'd24;
   localparam logic [KIND_W-1:0] KIND_LAND   = 6'd25;
   localparam logic [KIND_W-1:0] KIND_LOR    = 6'd26;
   localparam logic [KIND_W-1:0] KIND_GE     = 6'd27;
   localparam logic [KIND_W-1:0] KIND_LE     = 6'd28;
   localparam logic [KIND_W-1:0] KIND_EQ     = 6'd29;

   // characters
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_QUOTE  = 8'h22;

   // keywords, text right-justified, first char in the highest used byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "if", "for", "int", "str", "else", "type", "while", "float", "array",
      "struct", "define", "return", "callable"};
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd8};
   localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
      6'd30, 6'd31, 6'd2, 6'd4, 6'd32, 6'd33, 6'd34, 6'd3, 6'd35, 6'd36, 6'd37,
      6'd38, 6'd39};

   typedef struct packed {
      logic space;
      logic splitter;
      logic single_op;
   } char_class_type;

   typedef struct packed {
      logic [7:0]     ch;
      logic           eot;
      char_class_type cls;
   } queue_entry_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [POS_W-1:0]       first;
      logic [POS_W-1:0]       last;
      logic [TOKEN_LEN_W-1:0] len;
   } result_type;

   function automatic logic [KIND_W-1:0] sep_kind(input logic [7:0] c);
      logic [KIND_W-1:0] k;
      unique case (c)
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "[":     k = KIND_LBRACK;
         "]":     k = KIND_RBRACK;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
      logic [KIND_W-1:0] k;
      unique case (c)
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "/":     k = KIND_SLASH;
         "*":     k = KIND_STAR;
         "=":     k = KIND_ASSIGN;
         "<":     k = KIND_LT;
         ">":     k = KIND_GT;
         "%":     k = KIND_MOD;
         "!":     k = KIND_NOT;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] dual_kind(input logic [7:0] a,
                                                   input logic [7:0] b);
      logic [KIND_W-1:0] k;
      unique case ({a, b})
         "++":    k = KIND_INC;
         "--":    k = KIND_DEC;
         "**":    k = KIND_POW;
         "&&":    k = KIND_LAND;
         "||":    k = KIND_LOR;
         ">=":    k = KIND_GE;
         "<=":    k = KIND_LE;
         "==":    k = KIND_EQ;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   // h holds byte i at [i*8 +: 8]; n is the length, 15 when above eight
   function automatic logic [KIND_W-1:0] kw_kind(input logic [63:0] h,
                                                 input logic [3:0]  n);
      logic [KIND_W-1:0] k;
      logic              hit;
      k = KIND_ERROR;
      for (int i = 0; i < KW_COUNT; i++) begin
         hit = (n == KW_LEN[i]);
         for (int j = 0; j < HEAD_LEN; j++) begin
            if (j < int'(KW_LEN[i])) begin
               hit = hit && (h[j*8 +: 8] ==
                             KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j)*8 +: 8]);
            end
         end
         if (hit) begin
            k = KW_KIND[i];
         end
      end
      return k;
   endfunction

   function automatic char_class_type classify_char(input logic [7:0] c);
      char_class_type cls;
      cls.space     = (c == " ") || (c >= 8'd9 && c <= 8'd13);
      cls.splitter  = (sep_kind(c) != KIND_ERROR) || (c == ":");
      cls.single_op = (op_kind(c) != KIND_ERROR) || (c == "^") || (c == "&") ||
                      (c == "|");
      return cls;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/stok_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts source bytes, tags their character class and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  [7:0]                 req_char_in,
   input  wire                        req_end_of_text,
   output logic                       q_valid,
   output stok_pkg::queue_entry_type  q_entry,
   input  wire                        q_pop
);
   import stok_pkg::*;

   queue_entry_type entry_ff [2];
   queue_entry_type entry_in;
   logic [1:0]      count_ff, count_in;
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic            push;
   logic            pop;

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      entry_in.ch  = req_char_in;
      entry_in.eot = req_end_of_text;
      entry_in.cls = classify_char(req_char_in);
      wr_ptr_in    = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/stok_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Sequences word operations per byte, classifies tokens and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stok_back #(
   parameter int MAX_TOKEN_LEN = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  q_valid,
   input  stok_pkg::queue_entry_type            q_entry,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [stok_pkg::KIND_W-1:0]          rsp_lex_kind,
   output logic [stok_pkg::POS_W-1:0]           rsp_first_pos,
   output logic [stok_pkg::POS_W-1:0]           rsp_last_pos,
   output logic [stok_pkg::TOKEN_LEN_W-1:0]     rsp_token_len,
   output logic                                 rsp_run_end
);
   import stok_pkg::*;

   localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_OPS    = 3'd1;
   localparam logic [2:0] ST_EOT    = 3'd2;
   localparam logic [2:0] ST_FLUSH  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // op mask bits, executed lowest first
   localparam int OP_PRE  = 0;
   localparam int OP_APP1 = 1;
   localparam int OP_APP2 = 2;
   localparam int OP_POST = 3;

   logic [2:0]        st_ff, st_in, nxt_ff, nxt_in;
   logic [3:0]        mask_ff, mask_in;
   logic [7:0]        op_c1_ff, op_c1_in, op_c2_ff, op_c2_in;
   logic [POS_W-1:0]  op_p1_ff, op_p1_in;
   logic              eot_ff, eot_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        held_char_ff, held_char_in;
   char_class_type    held_cls_ff, held_cls_in;
   logic              held_valid_ff, held_valid_in;
   logic [7:0]        prior_ff, prior_in;
   logic              in_comment_ff, in_comment_in;
   logic              in_quote_ff, in_quote_in;
   logic [POS_W-1:0]  stream_pos_ff, stream_pos_in;
   logic              halted_ff, halted_in;
   logic [LEN_W-1:0]  word_len_ff, word_len_in;
   logic [7:0]        word_head_ff [HEAD_LEN];
   logic [7:0]        word_head_in [HEAD_LEN];
   logic [7:0]        word_tail_ff, word_tail_in;
   logic              all_dig_ff, all_dig_in;
   logic              seen_dot_ff, seen_dot_in;
   logic              float_ok_ff, float_ok_in;
   logic [POS_W-1:0]  first_ff, first_in, last_ff, last_in;
   logic              pend_valid_ff, pend_valid_in;
   result_type        pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;
   logic              out_end_ff, out_end_in;

   // decision for the held byte
   logic              dc_has_next;
   logic [7:0]        dc_c, dc_nx;
   logic [KIND_W-1:0] dc_dual;
   logic [3:0]        dc_mask;
   logic              dc_comment, dc_quote, dc_consumed;
   logic [7:0]        dc_prior;

   logic [63:0]       head_packed;
   logic [3:0]        len4;
   logic [LEN_W+10:0] len_wide;
   logic [TOKEN_LEN_W-1:0] len11;
   logic [KIND_W-1:0] word_kind;
   logic [KIND_W-1:0] kw;
   logic [KIND_W-1:0] dual_head;

   logic              emit_ok;
   logic              do_build, do_append, do_restart;
   logic [7:0]        app_c;
   logic [POS_W-1:0]  app_p;
   logic              emit_en;
   result_type        emit_res;

   assign rsp_valid      = out_valid_ff;
   assign rsp_lex_kind   = out_ff.kind;
   assign rsp_first_pos  = out_ff.first;
   assign rsp_last_pos   = out_ff.last;
   assign rsp_token_len  = out_ff.len;
   assign rsp_run_end    = out_end_ff;

   always_comb begin
      dc_has_next = (st_ff == ST_IDLE);
      dc_c        = held_char_ff;
      dc_nx       = q_entry.ch;
      dc_dual     = dc_has_next ? dual_kind(dc_c, dc_nx) : KIND_ERROR;
      dc_mask     = 4'b0000;
      dc_comment  = in_comment_ff;
      dc_quote    = in_quote_ff;
      dc_consumed = 1'b0;
      dc_prior    = dc_c;
      priority if (!in_comment_ff && dc_c == CH_SLASH && dc_has_next &&
                   dc_nx == CH_STAR) begin
         dc_comment = 1'b1;
      end else if (in_comment_ff) begin
         if (prior_ff == CH_STAR && dc_c == CH_SLASH) begin
            dc_comment = 1'b0;
         end
      end else if (held_cls_ff.space && !in_quote_ff) begin
         dc_mask[OP_PRE] = 1'b1;
      end else if (in_quote_ff && prior_ff != CH_BSLASH && dc_c == CH_QUOTE) begin
         dc_quote = 1'b0;
         dc_mask  = 4'b1010;
      end else if (!in_quote_ff && prior_ff != CH_BSLASH && dc_c == CH_QUOTE) begin
         dc_quote = 1'b1;
         dc_mask  = 4'b0011;
      end else if (!in_quote_ff && held_cls_ff.splitter) begin
         dc_mask = 4'b1011;
      end else if (!in_quote_ff && dc_dual != KIND_ERROR) begin
         dc_mask     = 4'b1111;
         dc_prior    = dc_nx;
         dc_consumed = 1'b1;
      end else if (!in_quote_ff && held_cls_ff.single_op) begin
         dc_mask = 4'b1011;
      end else begin
         dc_mask[OP_APP1] = 1'b1;
      end
   end

   // token classification from the word state
   always_comb begin
      for (int i = 0; i < HEAD_LEN; i++) begin
         head_packed[i*8 +: 8] = word_head_ff[i];
      end
      len4      = (word_len_ff > LEN_W'(HEAD_LEN)) ? 4'hF : word_len_ff[3:0];
      len_wide  = {11'b0, word_len_ff};
      len11     = len_wide[TOKEN_LEN_W-1:0];
      kw        = kw_kind(head_packed, len4);
      dual_head = dual_kind(word_head_ff[0], word_head_ff[1]);
      priority if (word_len_ff >= LEN_W'(2) && word_head_ff[0] == CH_QUOTE &&
                   word_tail_ff == CH_QUOTE) begin
         word_kind = KIND_STRING;
      end else if (word_len_ff >= LEN_W'(2) && float_ok_ff &&
                   word_tail_ff != CH_DOT) begin
         word_kind = KIND_FLOAT;
      end else if (word_len_ff == LEN_W'(2) && dual_head != KIND_ERROR) begin
         word_kind = dual_head;
      end else if (word_len_ff >= LEN_W'(2) && kw != KIND_ERROR) begin
         word_kind = kw;
      end else if (all_dig_ff) begin
         word_kind = KIND_INT;
      end else if (sep_kind(word_head_ff[0]) != KIND_ERROR) begin
         word_kind = sep_kind(word_head_ff[0]);
      end else if (op_kind(word_head_ff[0]) != KIND_ERROR) begin
         word_kind = op_kind(word_head_ff[0]);
      end else if ((word_head_ff[0] >= "A" && word_head_ff[0] <= "Z") ||
                   (word_head_ff[0] >= "a" && word_head_ff[0] <= "z")) begin
         word_kind = KIND_IDENT;
      end else begin
         word_kind = KIND_ERROR;
      end
   end

   always_comb begin
      st_in          = st_ff;
      nxt_in         = nxt_ff;
      mask_in        = mask_ff;
      op_c1_in       = op_c1_ff;
      op_c2_in       = op_c2_ff;
      op_p1_in       = op_p1_ff;
      eot_in         = eot_ff;
      pos_in         = pos_ff;
      held_char_in   = held_char_ff;
      held_cls_in    = held_cls_ff;
      held_valid_in  = held_valid_ff;
      prior_in       = prior_ff;
      in_comment_in  = in_comment_ff;
      in_quote_in    = in_quote_ff;
      stream_pos_in  = stream_pos_ff;
      halted_in      = halted_ff;
      word_len_in    = word_len_ff;
      word_head_in   = word_head_ff;
      word_tail_in   = word_tail_ff;
      all_dig_in     = all_dig_ff;
      seen_dot_in    = seen_dot_ff;
      float_ok_in    = float_ok_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      out_end_in     = out_end_ff;
      q_pop          = 1'b0;
      do_build       = 1'b0;
      do_append      = 1'b0;
      do_restart     = 1'b0;
      app_c          = op_c1_ff;
      app_p          = op_p1_ff;
      emit_en        = 1'b0;
      emit_res       = '0;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      emit_ok = !pend_valid_ff || !out_valid_ff || rsp_ready;

      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!halted_ff) begin
                  pos_in        = stream_pos_ff;
                  stream_pos_in = stream_pos_ff + 32'd1;
                  eot_in        = q_entry.eot;
                  nxt_in        = q_entry.eot ? ST_EOT : ST_FINISH;
                  held_char_in  = q_entry.ch;
                  held_cls_in   = q_entry.cls;
                  if (held_valid_ff) begin
                     mask_in       = dc_mask;
                     in_comment_in = dc_comment;
                     in_quote_in   = dc_quote;
                     prior_in      = dc_prior;
                     op_c1_in      = held_char_ff;
                     op_c2_in      = q_entry.ch;
                     op_p1_in      = stream_pos_ff - 32'd1;
                     held_valid_in = !dc_consumed;
                     st_in         = (dc_mask != 4'b0000) ? ST_OPS : nxt_in;
                  end else begin
                     held_valid_in = 1'b1;
                     st_in         = nxt_in;
                  end
               end
            end
         end
         ST_OPS: begin
            if (halted_ff) begin
               mask_in = 4'b0000;
               st_in   = ST_FINISH;
            end else if (emit_ok) begin
               priority if (mask_ff[OP_PRE]) begin
                  do_build = 1'b1;
               end else if (mask_ff[OP_APP1]) begin
                  do_append = 1'b1;
               end else if (mask_ff[OP_APP2]) begin
                  do_append = 1'b1;
                  app_c     = op_c2_ff;
                  app_p     = op_p1_ff + 32'd1;
               end else begin
                  do_build = 1'b1;
               end
               mask_in = mask_ff & (mask_ff - 4'd1);
               if (mask_in == 4'b0000) begin
                  st_in = nxt_ff;
               end
            end
         end
         ST_EOT: begin
            if (halted_ff) begin
               st_in = ST_FINISH;
            end else if (held_valid_ff) begin
               mask_in       = dc_mask;
               in_comment_in = dc_comment;
               in_quote_in   = dc_quote;
               prior_in      = dc_prior;
               op_c1_in      = held_char_ff;
               op_p1_in      = pos_ff;
               held_valid_in = 1'b0;
               nxt_in        = ST_FLUSH;
               st_in         = (dc_mask != 4'b0000) ? ST_OPS : ST_FLUSH;
            end else begin
               st_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (halted_ff) begin
               st_in = ST_FINISH;
            end else if (emit_ok) begin
               do_build   = 1'b1;
               do_restart = 1'b1;
               st_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff) begin
               st_in = ST_IDLE;
            end else if (!out_valid_ff || rsp_ready) begin
               out_in        = pend_ff;
               out_end_in    = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               st_in         = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // word operations
      if (do_build && word_len_ff != '0) begin
         emit_en        = 1'b1;
         emit_res.kind  = word_kind;
         emit_res.first = first_ff;
         emit_res.last  = last_ff;
         emit_res.len   = len11;
         word_len_in    = '0;
         all_dig_in     = 1'b1;
         seen_dot_in    = 1'b0;
         float_ok_in    = 1'b1;
         first_in       = '0;
         last_in        = '0;
      end
      if (do_append) begin
         if (word_len_ff >= LEN_W'(MAX_TOKEN_LEN)) begin
            emit_en        = 1'b1;
            emit_res.kind  = KIND_ERROR;
            emit_res.first = first_ff;
            emit_res.last  = app_p;
            emit_res.len   = len11;
         end else begin
            if (word_len_ff == '0) begin
               first_in = app_p;
            end
            if (word_len_ff < LEN_W'(HEAD_LEN)) begin
               word_head_in[word_len_ff[2:0]] = app_c;
            end
            if (!(app_c >= "0" && app_c <= "9")) begin
               all_dig_in = 1'b0;
               if (app_c == CH_DOT && !seen_dot_ff) begin
                  if (word_len_ff == '0) begin
                     float_ok_in = 1'b0;
                  end
                  seen_dot_in = 1'b1;
               end else begin
                  float_ok_in = 1'b0;
               end
            end
            word_tail_in = app_c;
            last_in      = app_p;
            word_len_in  = word_len_ff + LEN_W'(1);
         end
      end
      // end of text: back to the start of a new text
      if (do_restart) begin
         held_char_in  = 8'd0;
         held_valid_in = 1'b0;
         prior_in      = 8'd0;
         in_comment_in = 1'b0;
         in_quote_in   = 1'b0;
         stream_pos_in = '0;
         word_len_in   = '0;
         all_dig_in    = 1'b1;
         seen_dot_in   = 1'b0;
         float_ok_in   = 1'b1;
         first_in      = '0;
         last_in       = '0;
      end
      // hold the newest result back until we know whether it ends the run
      if (emit_en) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_end_in   = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = emit_res;
         pend_valid_in = 1'b1;
         if (emit_res.kind == KIND_ERROR) begin
            halted_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         nxt_ff        <= ST_IDLE;
         mask_ff       <= 4'b0000;
         held_char_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         prior_ff      <= 8'd0;
         in_comment_ff <= 1'b0;
         in_quote_ff   <= 1'b0;
         stream_pos_ff <= '0;
         halted_ff     <= 1'b0;
         word_len_ff   <= '0;
         all_dig_ff    <= 1'b1;
         seen_dot_ff   <= 1'b0;
         float_ok_ff   <= 1'b1;
         first_ff      <= '0;
         last_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         nxt_ff        <= nxt_in;
         mask_ff       <= mask_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         prior_ff      <= prior_in;
         in_comment_ff <= in_comment_in;
         in_quote_ff   <= in_quote_in;
         stream_pos_ff <= stream_pos_in;
         halted_ff     <= halted_in;
         word_len_ff   <= word_len_in;
         all_dig_ff    <= all_dig_in;
         seen_dot_ff   <= seen_dot_in;
         float_ok_ff   <= float_ok_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      op_c1_ff     <= op_c1_in;
      op_c2_ff     <= op_c2_in;
      op_p1_ff     <= op_p1_in;
      eot_ff       <= eot_in;
      pos_ff       <= pos_in;
      held_cls_ff  <= held_cls_in;
      word_head_ff <= word_head_in;
      word_tail_ff <= word_tail_in;
      pend_ff      <= pend_in;
      out_ff       <= out_in;
      out_end_ff   <= out_end_in;
   end

   // eot_ff records the transaction's end-of-text flag; only the check below reads it
   `STOK_ASSERT(a_eot_path, clock, reset, (st_ff == ST_EOT) |-> eot_ff)
   `STOK_ASSERT(a_halt_sticky, clock, reset, halted_ff |=> halted_ff)
   `STOK_ASSERT(a_ops_pending, clock, reset, (st_ff == ST_OPS) |-> (mask_ff != 4'b0000))
   `STOK_NEVER(a_len_bound, clock, reset, word_len_ff > LEN_W'(MAX_TOKEN_LEN))

endmodule

`default_nettype wire

FILE: rtl/source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Source tokenizer
// Streaming lexer: one source byte per transaction in, tokens out.
// ----------------------------------------------------------------------------
// Bytes enter a two-entry queue through the req_ channel. The back end pops
// one byte and, in that same cycle, decides what the previously held byte
// does; it then runs that byte's word operations one per cycle, unless they
// stall, and passes a closing state that releases the byte's last token. A
// byte needs no word operation inside a comment or as the first byte of a
// text, one when it extends a word or is whitespace, two at a quote, three
// for a separator or single operator and four for a two-char operator. The
// end-of-text byte adds a step to decide the held byte, up to three word
// operations for it and a flush step. Word operations stall while a result
// is pending and the output register is full and not drained.
// Each token leaves as one rsp_ transaction through an output register, with
// rsp_run_end set on the last token caused by a byte. An error token halts
// the block until reset; later bytes are accepted and dropped.
`default_nettype none

module source_tokenizer_top #(
   parameter int MAX_TOKEN_LEN = 1024
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [7:0]                        req_char_in,
   input  wire                               req_end_of_text,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [stok_pkg::KIND_W-1:0]       rsp_lex_kind,
   output logic [stok_pkg::POS_W-1:0]        rsp_first_pos,
   output logic [stok_pkg::POS_W-1:0]        rsp_last_pos,
   output logic [stok_pkg::TOKEN_LEN_W-1:0]  rsp_token_len,
   output logic                              rsp_run_end
);
   import stok_pkg::*;

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   stok_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop)
   );

   stok_back #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_lex_kind   (rsp_lex_kind),
      .rsp_first_pos  (rsp_first_pos),
      .rsp_last_pos   (rsp_last_pos),
      .rsp_token_len  (rsp_token_len),
      .rsp_run_end    (rsp_run_end)
   );

endmodule

`default_nettype wire

FILE: tb/tb_source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Streams source texts through the tokenizer and checks every token (kind,
// first and last position, length, last-of-byte flag) against a behavioral
// lexer kept in the bench. A directed table comes first, then random texts of
// well-formed tokens, and finally a stray colon that raises the error kind
// and halts the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_source_tokenizer_top;
   import stok_pkg::*;

   localparam int WORD_MAX      = 1024;
   localparam int IDLE_LIMIT    = 3000;
   localparam int RANDOM_ITEMS  = 280;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [KIND_W-1:0] KIND_CALLABLE = 6'd39;
   localparam logic [KIND_W-1:0] KIND_IF       = 6'd30;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [POS_W-1:0]       first;
      logic [POS_W-1:0]       last;
      logic [TOKEN_LEN_W-1:0] len;
      logic                   run_end;
   } token_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
      logic       typed;
      token_type  tok;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_char_in;
   logic                   req_end_of_text;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [KIND_W-1:0]      rsp_lex_kind;
   logic [POS_W-1:0]       rsp_first_pos;
   logic [POS_W-1:0]       rsp_last_pos;
   logic [TOKEN_LEN_W-1:0] rsp_token_len;
   logic                   rsp_run_end;

   source_tokenizer_top #(.MAX_TOKEN_LEN(WORD_MAX)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_lex_kind    (rsp_lex_kind),
      .rsp_first_pos   (rsp_first_pos),
      .rsp_last_pos    (rsp_last_pos),
      .rsp_token_len   (rsp_token_len),
      .rsp_run_end     (rsp_run_end)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------- lexer
   logic [7:0]  lx_held, lx_prior, lx_tail;
   logic [7:0]  lx_head [HEAD_LEN];
   bit          lx_held_v, lx_in_cmt, lx_in_q, lx_halted;
   bit          lx_all_dig, lx_seen_dot, lx_float_ok;
   int unsigned lx_len;
   logic [31:0] lx_first, lx_last, lx_pos;
   token_type   step_toks[$];
   token_type   tok_expect[$];

   function automatic logic [KIND_W-1:0] sep_code(input logic [7:0] c);
      case (c)
         "(": return KIND_LPAREN;
         ")": return KIND_RPAREN;
         "[": return KIND_LBRACK;
         "]": return KIND_RBRACK;
         "{": return KIND_LBRACE;
         "}": return KIND_RBRACE;
         ",": return KIND_COMMA;
         ";": return KIND_SEMI;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] op_code(input logic [7:0] c);
      case (c)
         "+": return KIND_PLUS;
         "-": return KIND_MINUS;
         "/": return KIND_SLASH;
         "*": return KIND_STAR;
         "=": return KIND_ASSIGN;
         "<": return KIND_LT;
         ">": return KIND_GT;
         "%": return KIND_MOD;
         "!": return KIND_NOT;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pair_code(input logic [7:0] a, input logic [7:0] b);
      case ({a, b})
         "++": return KIND_INC;
         "--": return KIND_DEC;
         "**": return KIND_POW;
         "&&": return KIND_LAND;
         "||": return KIND_LOR;
         ">=": return KIND_GE;
         "<=": return KIND_LE;
         "==": return KIND_EQ;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void clear_word();
      lx_len = 0;
      foreach (lx_head[i]) lx_head[i] = 8'h00;
      lx_tail = 8'h00;
      lx_all_dig = 1'b1;
      lx_seen_dot = 1'b0;
      lx_float_ok = 1'b1;
      lx_first = 0;
      lx_last = 0;
   endfunction

   function automatic void clear_text();
      lx_held = 8'h00;
      lx_held_v = 1'b0;
      lx_prior = 8'h00;
      lx_in_cmt = 1'b0;
      lx_in_q = 1'b0;
      clear_word();
      lx_pos = 0;
   endfunction

   function automatic void add_token(input logic [KIND_W-1:0] kind, input logic [31:0] first,
                                     input logic [31:0] last, input int unsigned len);
      if (step_toks.size() >= 4) return;
      step_toks.push_back('{kind, first, last, len[TOKEN_LEN_W-1:0], 1'b0});
      if (kind == KIND_ERROR) lx_halted = 1'b1;
   endfunction

   function automatic logic [KIND_W-1:0] word_kind();
      logic [KIND_W-1:0] k;
      bit                hit;
      int                n;
      if (lx_len >= 2) begin
         if (lx_head[0] == CH_QUOTE && lx_tail == CH_QUOTE) return KIND_STRING;
         if (lx_float_ok && lx_tail != CH_DOT) return KIND_FLOAT;
         if (lx_len == 2) begin
            k = pair_code(lx_head[0], lx_head[1]);
            if (k != KIND_ERROR) return k;
         end
         for (int i = 0; i < KW_COUNT; i++) begin
            n = int'(KW_LEN[i]);
            hit = (lx_len == n);
            for (int j = 0; j < HEAD_LEN; j++)
               if (j < n && lx_head[j] != KW_TEXT[i][(n - 1 - j)*8 +: 8]) hit = 1'b0;
            if (hit) return KW_KIND[i];
         end
      end
      if (lx_all_dig) return KIND_INT;
      k = sep_code(lx_head[0]);
      if (k != KIND_ERROR) return k;
      k = op_code(lx_head[0]);
      if (k != KIND_ERROR) return k;
      if ((lx_head[0] >= "A" && lx_head[0] <= "Z") || (lx_head[0] >= "a" && lx_head[0] <= "z"))
         return KIND_IDENT;
      return KIND_ERROR;
   endfunction

   function automatic void close_word();
      if (lx_halted || lx_len == 0) return;
      add_token(word_kind(), lx_first, lx_last, lx_len);
      clear_word();
   endfunction

   function automatic void grow_word(input logic [7:0] c, input logic [31:0] pos);
      if (lx_halted) return;
      if (lx_len >= WORD_MAX) begin
         add_token(KIND_ERROR, lx_first, pos, lx_len);
         return;
      end
      if (lx_len == 0) lx_first = pos;
      if (lx_len < HEAD_LEN) lx_head[lx_len] = c;
      if (!is_digit(c)) begin
         lx_all_dig = 1'b0;
         if (c == CH_DOT && !lx_seen_dot) begin
            if (lx_len == 0) lx_float_ok = 1'b0;
            lx_seen_dot = 1'b1;
         end else begin
            lx_float_ok = 1'b0;
         end
      end
      lx_tail = c;
      lx_last = pos;
      lx_len++;
   endfunction

   // returns 1 when the lookahead byte went into a two-char operator
   function automatic bit scan_byte(input logic [7:0] c, input logic [31:0] pos,
                                    input bit has_nx, input logic [7:0] nx);
      if (!lx_in_cmt) begin
         if (c == CH_SLASH && has_nx && nx == CH_STAR) begin
            lx_in_cmt = 1'b1;
            lx_prior = c;
            return 1'b0;
         end
      end else begin
         if (lx_prior == CH_STAR && c == CH_SLASH) lx_in_cmt = 1'b0;
         lx_prior = c;
         return 1'b0;
      end
      if (is_blank(c) && !lx_in_q) begin
         close_word();
      end else if (lx_in_q && lx_prior != CH_BSLASH && c == CH_QUOTE) begin
         lx_in_q = 1'b0;
         grow_word(c, pos);
         close_word();
      end else if (!lx_in_q && lx_prior != CH_BSLASH && c == CH_QUOTE) begin
         lx_in_q = 1'b1;
         close_word();
         grow_word(c, pos);
      end else if (!lx_in_q && (sep_code(c) != KIND_ERROR || c == ":")) begin
         close_word();
         grow_word(c, pos);
         close_word();
      end else if (!lx_in_q && has_nx && pair_code(c, nx) != KIND_ERROR) begin
         close_word();
         grow_word(c, pos);
         grow_word(nx, pos + 1);
         close_word();
         lx_prior = nx;
         return 1'b1;
      end else if (!lx_in_q && (op_code(c) != KIND_ERROR || c == "^" || c == "&" || c == "|"))
      begin
         close_word();
         grow_word(c, pos);
         close_word();
      end else begin
         grow_word(c, pos);
      end
      lx_prior = c;
      return 1'b0;
   endfunction

   function automatic void lex_byte(input logic [7:0] c, input bit eot);
      logic [31:0] pos;
      bit          used;
      step_toks.delete();
      if (lx_halted) return;
      pos = lx_pos;
      lx_pos++;
      used = 1'b0;
      if (lx_held_v) begin
         used = scan_byte(lx_held, pos - 1, 1'b1, c);
         lx_held_v = 1'b0;
      end
      if (!used && !lx_halted) begin
         lx_held = c;
         lx_held_v = 1'b1;
      end
      if (eot && !lx_halted) begin
         if (lx_held_v) begin
            lx_held_v = 1'b0;
            void'(scan_byte(lx_held, pos, 1'b0, 8'h00));
         end
         close_word();
         if (!lx_halted) clear_text();
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].run_end = 1'b1;
   endfunction

   // ---------------------------------------------------------------- checker
   int errs = 0;
   int toks_seen = 0;
   int bytes_sent = 0;
   int texts_sent = 0;
   int idle_cycles = 0;
   bit calm = 1'b1;
   bit hold_req = 1'b0;

   function automatic void cmp_field(input string name, input logic [31:0] exp,
                                     input logic [31:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      token_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         toks_seen++;
         if (tok_expect.size() == 0) begin
            $display("%0t: unexpected token, expected none, got kind %0d at %0d", $time,
                     rsp_lex_kind, rsp_first_pos);
            errs++;
         end else begin
            exp = tok_expect.pop_front();
            cmp_field("lex_kind", exp.kind, rsp_lex_kind);
            cmp_field("first_pos", exp.first, rsp_first_pos);
            cmp_field("last_pos", exp.last, rsp_last_pos);
            cmp_field("token_len", exp.len, rsp_token_len);
            cmp_field("run_end", exp.run_end, rsp_run_end);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_source_tokenizer_top NOT OK");
            $finish;
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 6);
         end
      end
   end

   // ---------------------------------------------------------------- sender
   logic [7:0] text_q[$];

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] c, input bit eot, input bit typed,
                            input token_type typed_tok);
      while (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      lex_byte(c, eot);
      if (typed) tok_expect.push_back(typed_tok);
      else foreach (step_toks[i]) tok_expect.push_back(step_toks[i]);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
      text_q.delete();
      texts_sent++;
   endtask

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0") + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_blank();
      logic [7:0] b;
      b = 8'($urandom_range(8, 13));
      return (b == 8'd8) ? 8'(" ") : b;
   endfunction

   // append one well-formed token, at times with a separator glued on, then whitespace
   task automatic put_token();
      string singles = "+-/*=<>%!";
      string pairs   = "++--**&&||>=<===";
      string seps    = "()[]{},;";
      int    n, k;
      case ($urandom_range(9))
         0, 1: begin
            text_q.push_back(rand_letter());
            n = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
            repeat (n) begin
               case ($urandom_range(5))
                  0: text_q.push_back(rand_letter());
                  1: text_q.push_back(rand_digit());
                  2: text_q.push_back($urandom_range(1) ? 8'("_") : CH_DOT);
                  3: text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
                  4: text_q.push_back(8'($urandom_range(0, 8)));
                  default: text_q.push_back(rand_letter());
               endcase
            end
         end
         2: repeat ($urandom_range(1, 4)) text_q.push_back(rand_digit());
         3: begin
            repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
            text_q.push_back(CH_DOT);
            repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
         end
         4: begin
            k = $urandom_range(KW_COUNT - 1);
            n = int'(KW_LEN[k]);
            for (int j = 0; j < n; j++) text_q.push_back(KW_TEXT[k][(n - 1 - j)*8 +: 8]);
         end
         5: text_q.push_back(singles[$urandom_range(singles.len() - 1)]);
         6: begin
            k = $urandom_range(7);
            text_q.push_back(pairs[2*k]);
            text_q.push_back(pairs[2*k+1]);
         end
         7: text_q.push_back(seps[$urandom_range(seps.len() - 1)]);
         8: begin
            text_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(5) == 0) begin
                  text_q.push_back(CH_BSLASH);
                  text_q.push_back(CH_QUOTE);
               end else begin
                  text_q.push_back($urandom_range(3) == 0 ? 8'(" ") : rand_letter());
               end
            end
            text_q.push_back(CH_QUOTE);
         end
         default: begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_STAR);
            if ($urandom_range(3) != 0) begin
               repeat ($urandom_range(0, 4))
                  text_q.push_back($urandom_range(2) == 0 ? 8'(" ") : rand_letter());
               text_q.push_back(CH_STAR);
            end
            text_q.push_back(CH_SLASH);
         end
      endcase
      // glue a separator straight on now and then
      if ($urandom_range(7) == 0) text_q.push_back(seps[$urandom_range(seps.len() - 1)]);
      text_q.push_back(rand_blank());
   endtask

   // "if (x)++ "a\"b"/*c*/;"  then  "a\x00\xFF callable ==5"
   dir_row_type dir_tab[] = '{
      '{"i", 1'b0, 1'b0, '0},
      '{"f", 1'b0, 1'b0, '0},
      '{" ", 1'b0, 1'b0, '0},
      '{"(", 1'b0, 1'b1, '{KIND_IF, 32'd0, 32'd1, 11'd2, 1'b1}},
      '{"x", 1'b0, 1'b1, '{KIND_LPAREN, 32'd3, 32'd3, 11'd1, 1'b1}},
      '{")", 1'b0, 1'b0, '0},
      '{"+", 1'b0, 1'b0, '0},
      '{"+", 1'b0, 1'b1, '{KIND_INC, 32'd6, 32'd7, 11'd2, 1'b1}},
      '{" ", 1'b0, 1'b0, '0},
      '{"\"", 1'b0, 1'b0, '0},
      '{"a", 1'b0, 1'b0, '0},
      '{"\\", 1'b0, 1'b0, '0},
      '{"\"", 1'b0, 1'b0, '0},
      '{"b", 1'b0, 1'b0, '0},
      '{"\"", 1'b0, 1'b0, '0},
      '{"/", 1'b0, 1'b0, '0},
      '{"*", 1'b0, 1'b0, '0},
      '{"c", 1'b0, 1'b0, '0},
      '{"*", 1'b0, 1'b0, '0},
      '{"/", 1'b0, 1'b0, '0},
      '{";", 1'b1, 1'b1, '{KIND_SEMI, 32'd20, 32'd20, 11'd1, 1'b1}},
      '{"a", 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{" ", 1'b0, 1'b0, '0},
      '{"c", 1'b0, 1'b1, '{KIND_IDENT, 32'd0, 32'd2, 11'd3, 1'b1}},
      '{"a", 1'b0, 1'b0, '0},
      '{"l", 1'b0, 1'b0, '0},
      '{"l", 1'b0, 1'b0, '0},
      '{"a", 1'b0, 1'b0, '0},
      '{"b", 1'b0, 1'b0, '0},
      '{"l", 1'b0, 1'b0, '0},
      '{"e", 1'b0, 1'b0, '0},
      '{" ", 1'b0, 1'b0, '0},
      '{"=", 1'b0, 1'b1, '{KIND_CALLABLE, 32'd4, 32'd11, 11'd8, 1'b1}},
      '{"=", 1'b0, 1'b1, '{KIND_EQ, 32'd13, 32'd14, 11'd2, 1'b1}},
      '{"5", 1'b1, 1'b1, '{KIND_INT, 32'd15, 32'd15, 11'd1, 1'b1}}
   };

   initial begin
      int rand_bytes;
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_in = 8'h00;
      req_end_of_text = 1'b0;
      lx_halted = 1'b0;
      clear_text();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i]) send_byte(dir_tab[i].ch, dir_tab[i].eot, dir_tab[i].typed,
                                     dir_tab[i].tok);

      // random texts: calm stretch first, then stalls and long hold-offs on request
      rand_bytes = 0;
      while (rand_bytes < RANDOM_ITEMS) begin
         calm = (rand_bytes < 100);
         if (rand_bytes >= 180 && rand_bytes < 200) hold_req = 1'b1;
         repeat ($urandom_range(2, 12)) put_token();
         // end some texts right on the last token byte
         if ($urandom_range(1)) void'(text_q.pop_back());
         rand_bytes += text_q.size();
         send_text();
      end

      // a stray colon raises the error kind; later bytes are dropped
      text_q = '{"a", "b", ":", "c", "d", ";"};
      send_text();
      req_valid <= 1'b0;

      while (tok_expect.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d bytes in %0d texts, %0d tokens checked, ending in error halt",
               bytes_sent, texts_sent, toks_seen);
      if (errs == 0) begin
         $display("tb_source_tokenizer_top OK");
      end else begin
         $display("tb_source_tokenizer_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
